FILE: rtl/core/slot_pool_free_stack_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the slot pool RTL
// Each macro expects clk and rst_n in scope of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_FREE_STACK_TOP_DEFINES_SVH
`define SLOT_POOL_FREE_STACK_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SPFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SPFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/spfs_pkg.sv
// ----------------------------------------------------------------------------
// spfs_pkg
// Types, codes and helpers for the slot pool with a free-id stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spfs_pkg;

  // Pool geometry
  localparam int unsigned SLOTS          = 256;
  localparam int unsigned SLOT_BYTES_MAX = 8;
  localparam int unsigned ADDR_W         = $clog2(SLOTS);

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned BCNT_W     = 4;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Stream packing
  localparam int unsigned IN_FIELDS_W  = ID_W + DATA_W + BCNT_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STAT_W + ID_W + DATA_W + 3 * CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [BCNT_W-1:0] SB_MAX    = BCNT_W'(SLOT_BYTES_MAX);

  typedef enum logic [OP_W-1:0] {
    OP_STORE = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SIZE = 2'd2,
    STAT_BAD  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROWABLE   = 2'd0,
    CFG_INIT_SLOTS = 2'd1,
    CFG_GROW_STEP  = 2'd2,
    CFG_SLOT_BYTES = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_POP   = 2'd1,
    ST_MERGE = 2'd2,
    ST_RDATA = 2'd3
  } state_t;

  // Mask covering the low n bytes of a data word
  function automatic logic [DATA_W-1:0] byte_mask(input logic [BCNT_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (BCNT_W'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/spfs_ram.sv
// ----------------------------------------------------------------------------
// spfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/slot_pool_free_stack_top.sv
// ----------------------------------------------------------------------------
// slot_pool_free_stack_top
// Slot pool of 8-byte data slots with a LIFO stack of recycled slot ids.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one request: op in in_tuser (store, free, read), slot id,
//   store data and byte count in in_tdata. out_* returns exactly one result
//   per request: status, given id, read data and the used, free and capacity
//   counts taken after the request. cfg_* writes a register;
//   writing initial_slots reinitializes the pool. Configure only while idle.
// Sequencing:
//   A free and every rejected request load the result register when taken;
//   a valid read passes through RDATA, a store of a fresh id through MERGE,
//   and a store of a recycled id through POP and then MERGE. The next
//   request is taken once the previous one has finished; a read waits on the
//   slot RAM read, and a store on the stack RAM read followed by the
//   read-modify-write of the slot RAM.
// Reset (rst_n, synchronous): capacity 256, stack and fresh counter empty;
//   slot and stack RAM contents are undefined until written.
// Stall: one output register holds the result; a stalled receiver holds off
//   in_tready until the register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_pool_free_stack_top_defines.svh"

module slot_pool_free_stack_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: slot_id[7:0], data_in[71:8], byte_count[75:72], zero pad
  input  logic [spfs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: op[1:0]
  input  logic [spfs_pkg::OP_W-1:0]           in_tuser,
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: status[1:0], given_id[9:2], read_data[73:10], used_count[82:74],
  //        free_count[91:83], capacity_now[100:92], zero pad
  output logic [spfs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [spfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned CNT_W  = spfs_pkg::CNT_W;
  localparam int unsigned ID_W   = spfs_pkg::ID_W;
  localparam int unsigned AW     = spfs_pkg::ADDR_W;
  localparam int unsigned DATA_W = spfs_pkg::DATA_W;
  localparam int unsigned BCNT_W = spfs_pkg::BCNT_W;
  localparam int unsigned PAD_W  = spfs_pkg::OUT_TDATA_W - spfs_pkg::OUT_FIELDS_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  spfs_pkg::state_t         state_r, state_nxt;
  logic                     growable_r;
  logic [CNT_W-1:0]         grow_step_r;
  logic [BCNT_W-1:0]        slot_bytes_r;
  logic [CNT_W-1:0]         rc_r, rc_nxt;
  logic [CNT_W-1:0]         fresh_r, fresh_nxt;
  logic [CNT_W-1:0]         cap_r, cap_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic [DATA_W-1:0]        data_r;
  logic [BCNT_W-1:0]        bcnt_r;

  logic                     out_valid_r;
  spfs_pkg::status_t        out_status_r;
  logic [ID_W-1:0]          out_given_r;
  logic [DATA_W-1:0]        out_rdata_r;
  logic [CNT_W-1:0]         out_used_r;
  logic [CNT_W-1:0]         out_free_r;
  logic [CNT_W-1:0]         out_cap_r;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  spfs_pkg::op_t            in_op;
  logic [ID_W-1:0]          in_sid;
  logic [DATA_W-1:0]        in_data;
  logic [BCNT_W-1:0]        in_bcnt;
  logic                     out_room;
  logic                     accept;

  assign in_op   = spfs_pkg::op_t'(in_tuser);
  assign in_sid  = in_tdata[ID_W-1:0];
  assign in_data = in_tdata[ID_W +: DATA_W];
  assign in_bcnt = in_tdata[ID_W+DATA_W +: BCNT_W];

  assign out_room  = !out_valid_r || out_tready;
  assign in_tready = (state_r == spfs_pkg::ST_IDLE) && out_room;
  assign accept    = in_tvalid && in_tready;

  // Pool checks against current state
  logic [BCNT_W-1:0]        sb_eff;
  logic [CNT_W-1:0]         free_now;
  logic [CNT_W-1:0]         room;
  logic [CNT_W-1:0]         grow_add;
  logic                     no_id;
  logic                     size_bad;
  logic                     store_go;
  logic                     sid_ok;
  logic                     free_ok;
  logic [CNT_W-1:0]         rc_dec;

  always_comb begin
    sb_eff   = (slot_bytes_r > spfs_pkg::SB_MAX) ? spfs_pkg::SB_MAX : slot_bytes_r;
    free_now = rc_r + (cap_r - fresh_r);
    room     = spfs_pkg::SLOTS_CNT - cap_r;
    grow_add = growable_r ? ((grow_step_r < room) ? grow_step_r : room) : '0;
    no_id    = (rc_r == '0) && (fresh_r >= cap_r);
    size_bad = in_bcnt > sb_eff;
    store_go = !size_bad && !(no_id && (grow_add == '0));
    sid_ok   = {1'b0, in_sid} < cap_r;
    free_ok  = sid_ok && (free_now < cap_r);
    rc_dec   = rc_r - CNT_W'(1);
  end

  // --------------------------------------------------------------------------
  // Memories: slot data and recycled-id stack
  // --------------------------------------------------------------------------
  logic                     slot_we, slot_re;
  logic [AW-1:0]            slot_waddr, slot_raddr;
  logic [DATA_W-1:0]        slot_wdata, slot_rdata;
  logic                     stk_we, stk_re;
  logic [AW-1:0]            stk_waddr, stk_raddr;
  logic [ID_W-1:0]          stk_wdata, stk_rdata;

  spfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (spfs_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  spfs_ram #(
    .WIDTH (ID_W),
    .DEPTH (spfs_pkg::SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Partial store keeps bytes above byte_count
  logic [DATA_W-1:0]        store_mask;
  assign store_mask = spfs_pkg::byte_mask(bcnt_r);
  assign slot_wdata = (slot_rdata & ~store_mask) | (data_r & store_mask);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            spfs_pkg::OP_STORE: begin
              if (store_go) begin
                state_nxt = (rc_r != '0) ? spfs_pkg::ST_POP : spfs_pkg::ST_MERGE;
              end
            end
            spfs_pkg::OP_READ: begin
              if (sid_ok) begin
                state_nxt = spfs_pkg::ST_RDATA;
              end
            end
            spfs_pkg::OP_FREE, spfs_pkg::OP_BAD: begin
              state_nxt = spfs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      spfs_pkg::ST_POP:   state_nxt = spfs_pkg::ST_MERGE;
      spfs_pkg::ST_MERGE: if (out_room) state_nxt = spfs_pkg::ST_IDLE;
      spfs_pkg::ST_RDATA: if (out_room) state_nxt = spfs_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control, result and pool counters
  // --------------------------------------------------------------------------
  logic                     res_vld;
  spfs_pkg::status_t        res_status;
  logic [ID_W-1:0]          res_given;
  logic [DATA_W-1:0]        res_rdata;

  always_comb begin
    rc_nxt     = rc_r;
    fresh_nxt  = fresh_r;
    cap_nxt    = cap_r;
    id_nxt     = id_r;
    stk_we     = 1'b0;
    stk_waddr  = rc_r[AW-1:0];
    stk_wdata  = in_sid;
    stk_re     = 1'b0;
    stk_raddr  = rc_dec[AW-1:0];
    slot_we    = 1'b0;
    slot_waddr = id_r;
    slot_re    = 1'b0;
    slot_raddr = in_sid;
    res_vld    = 1'b0;
    res_status = spfs_pkg::STAT_OK;
    res_given  = '0;
    res_rdata  = '0;

    unique case (state_r)
      spfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            spfs_pkg::OP_STORE: begin
              if (size_bad) begin
                res_vld    = 1'b1;
                res_status = spfs_pkg::STAT_SIZE;
              end else if (!store_go) begin
                res_vld    = 1'b1;
                res_status = spfs_pkg::STAT_FULL;
              end else begin
                if (no_id) begin
                  cap_nxt = cap_r + grow_add;
                end
                // Recycled ids first, then the fresh counter
                if (rc_r != '0) begin
                  rc_nxt = rc_dec;
                  stk_re = 1'b1;
                end else begin
                  id_nxt     = fresh_r[AW-1:0];
                  fresh_nxt  = fresh_r + CNT_W'(1);
                  slot_re    = 1'b1;
                  slot_raddr = fresh_r[AW-1:0];
                end
              end
            end
            spfs_pkg::OP_FREE: begin
              res_vld = 1'b1;
              if (free_ok) begin
                stk_we = 1'b1;
                rc_nxt = rc_r + CNT_W'(1);
              end else begin
                res_status = spfs_pkg::STAT_BAD;
              end
            end
            spfs_pkg::OP_READ: begin
              if (sid_ok) begin
                slot_re = 1'b1;
              end else begin
                res_vld    = 1'b1;
                res_status = spfs_pkg::STAT_BAD;
              end
            end
            spfs_pkg::OP_BAD: begin
              res_vld    = 1'b1;
              res_status = spfs_pkg::STAT_BAD;
            end
          endcase
        end
      end
      // Popped id arrives; fetch the old slot word
      spfs_pkg::ST_POP: begin
        id_nxt     = stk_rdata;
        slot_re    = 1'b1;
        slot_raddr = stk_rdata;
      end
      // Merge and write back; repeat is harmless while read data holds
      spfs_pkg::ST_MERGE: begin
        slot_we   = 1'b1;
        res_vld   = 1'b1;
        res_given = id_r;
      end
      spfs_pkg::ST_RDATA: begin
        res_vld   = 1'b1;
        res_rdata = slot_rdata & spfs_pkg::byte_mask(sb_eff);
      end
    endcase

    // Writing initial_slots reinitializes the pool
    if (cfg_we && (spfs_pkg::cfg_idx_t'(cfg_index) == spfs_pkg::CFG_INIT_SLOTS)) begin
      cap_nxt   = (cfg_wdata > spfs_pkg::SLOTS_CNT) ? spfs_pkg::SLOTS_CNT : cfg_wdata;
      rc_nxt    = '0;
      fresh_nxt = '0;
    end
  end

  // Counts after the request
  logic [CNT_W-1:0]         free_nxt;
  logic [CNT_W-1:0]         used_nxt;
  logic                     out_load;

  assign free_nxt = rc_nxt + (cap_nxt - fresh_nxt);
  assign used_nxt = cap_nxt - free_nxt;
  assign out_load = res_vld && out_room;

  // --------------------------------------------------------------------------
  // Control and configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spfs_pkg::ST_IDLE;
      growable_r   <= 1'b0;
      grow_step_r  <= '0;
      slot_bytes_r <= spfs_pkg::SB_MAX;
      rc_r         <= '0;
      fresh_r      <= '0;
      cap_r        <= spfs_pkg::SLOTS_CNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rc_r    <= rc_nxt;
      fresh_r <= fresh_nxt;
      cap_r   <= cap_nxt;
      if (cfg_we) begin
        unique case (spfs_pkg::cfg_idx_t'(cfg_index))
          spfs_pkg::CFG_GROWABLE:   growable_r   <= cfg_wdata[0];
          spfs_pkg::CFG_INIT_SLOTS: growable_r   <= growable_r;
          spfs_pkg::CFG_GROW_STEP:  grow_step_r  <= cfg_wdata;
          spfs_pkg::CFG_SLOT_BYTES: slot_bytes_r <= cfg_wdata[BCNT_W-1:0];
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (accept) begin
      data_r <= in_data;
      bcnt_r <= in_bcnt;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_given_r  <= res_given;
      out_rdata_r  <= res_rdata;
      out_used_r   <= used_nxt;
      out_free_r   <= free_nxt;
      out_cap_r    <= cap_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_cap_r, out_free_r, out_used_r,
                       out_rdata_r, out_given_r, out_status_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPFS_ASSERT_IMP(a_rc_le_fresh, 1'b1, rc_r <= fresh_r, "recycled count exceeds issued ids")
  `SPFS_ASSERT_IMP(a_fresh_le_cap, 1'b1, fresh_r <= cap_r, "fresh counter beyond capacity")
  `SPFS_ASSERT_IMP(a_cap_le_slots, 1'b1, cap_r <= spfs_pkg::SLOTS_CNT, "capacity beyond pool size")
  `SPFS_ASSERT_NXT(a_pop_to_merge, state_r == spfs_pkg::ST_POP, state_r == spfs_pkg::ST_MERGE, "pop not followed by merge")
  `SPFS_ASSERT_NXT(a_read_fetch, accept && (in_op == spfs_pkg::OP_READ) && sid_ok, state_r == spfs_pkg::ST_RDATA, "valid read did not fetch slot")

endmodule

FILE: dv/slot_pool_checker.sv
// ----------------------------------------------------------------------------
// slot_pool_checker
// Watches the request, result and register ports of the slot pool. Keeps its
// own copy of the pool (slot words, recycled-id stack, fresh counter,
// capacity, registers), predicts one response per accepted request and
// compares every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_pool_checker
  import spfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // tdata: slot_id, data_in, byte_count, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: op
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: status, given_id, read_data, used, free, capacity, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending_count
);

  // Result fields, status in the low bits as on the wire
  typedef struct packed {
    logic [CNT_W-1:0]  capacity_now;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
    logic [DATA_W-1:0] read_data;
    logic [ID_W-1:0]   given_id;
    status_t           status;
  } pool_resp_t;

  pool_resp_t pending_responses[$];

  // Shadow pool
  logic [DATA_W-1:0] slot_words [SLOTS];
  logic [ID_W-1:0]   recycled [SLOTS];
  int unsigned       recycled_depth;
  int unsigned       fresh_id;
  int unsigned       pool_cap;

  // Shadow registers
  bit                growable_q;
  int unsigned       init_slots_q;
  int unsigned       grow_step_q;
  int unsigned       slot_bytes_q;

  int n_fail = 0;
  int n_results = 0;

  assign fail_count = n_fail;

  task automatic report_fail(input string msg);
    $display("ERROR: %s", msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_fail($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                            n_results, name, got, want));
    end
  endtask

  // Low n bytes set
  function automatic logic [DATA_W-1:0] lane_mask(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  function automatic int unsigned ids_available();
    return recycled_depth + (pool_cap - fresh_id);
  endfunction

  task automatic reinit_pool();
    pool_cap       = (init_slots_q > SLOTS) ? SLOTS : init_slots_q;
    recycled_depth = 0;
    fresh_id       = 0;
  endtask

  task automatic reset_pool();
    growable_q   = 1'b0;
    init_slots_q = 256;
    grow_step_q  = 0;
    slot_bytes_q = 8;
    reinit_pool();
  endtask

  // One request against the shadow pool; counts are taken afterwards
  function automatic pool_resp_t predict_response(input op_t op,
                                                  input logic [ID_W-1:0] sid,
                                                  input logic [DATA_W-1:0] data,
                                                  input logic [BCNT_W-1:0] cnt);
    pool_resp_t        r;
    int unsigned       sb;
    int unsigned       add;
    int unsigned       id;
    int unsigned       avail;
    bit                have;
    logic [DATA_W-1:0] m;
    r  = '0;
    sb = (slot_bytes_q > SLOT_BYTES_MAX) ? SLOT_BYTES_MAX : slot_bytes_q;
    case (op)
      OP_STORE: begin
        // size is checked before anything else
        if (cnt > sb) begin
          r.status = STAT_SIZE;
        end else begin
          have = 1'b1;
          if (recycled_depth == 0 && fresh_id >= pool_cap) begin
            add = 0;
            if (growable_q) begin
              add = SLOTS - pool_cap;
              if (grow_step_q < add) add = grow_step_q;
            end
            if (add == 0) have = 1'b0;
            else pool_cap += add;
          end
          if (!have) begin
            r.status = STAT_FULL;
          end else begin
            // recycled ids first, LIFO
            if (recycled_depth > 0) begin
              recycled_depth--;
              id = recycled[recycled_depth];
            end else begin
              id = fresh_id;
              fresh_id++;
            end
            m = lane_mask(cnt);
            slot_words[id[ID_W-1:0]] = (slot_words[id[ID_W-1:0]] & ~m) | (data & m);
            r.given_id = id[ID_W-1:0];
          end
        end
      end
      OP_FREE: begin
        // no double-free detection
        if (sid >= pool_cap || ids_available() >= pool_cap) begin
          r.status = STAT_BAD;
        end else begin
          recycled[recycled_depth] = sid;
          recycled_depth++;
        end
      end
      OP_READ: begin
        if (sid >= pool_cap) r.status = STAT_BAD;
        else r.read_data = slot_words[sid] & lane_mask(sb);
      end
      default: r.status = STAT_BAD;
    endcase
    avail          = ids_available();
    r.used_count   = CNT_W'(pool_cap - avail);
    r.free_count   = CNT_W'(avail);
    r.capacity_now = CNT_W'(pool_cap);
    return r;
  endfunction

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_GROWABLE:   growable_q = val[0];
      CFG_INIT_SLOTS: begin
        init_slots_q = val;
        reinit_pool();
      end
      CFG_GROW_STEP:  grow_step_q = val;
      CFG_SLOT_BYTES: slot_bytes_q = val[BCNT_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    pool_resp_t got;
    pool_resp_t want;
    if (!rst_n) begin
      pending_responses.delete();
      reset_pool();
    end else begin
      // results first: a result at this edge belongs to an older request
      if (out_tvalid && out_tready) begin
        n_results++;
        got = pool_resp_t'(out_tdata[OUT_FIELDS_W-1:0]);
        if (pending_responses.size() == 0) begin
          report_fail($sformatf("result %0d arrived with no request outstanding",
                                n_results));
        end else begin
          want = pending_responses.pop_front();
          check_field("status", got.status, want.status);
          check_field("given_id", got.given_id, want.given_id);
          check_field("read_data", got.read_data, want.read_data);
          check_field("used_count", got.used_count, want.used_count);
          check_field("free_count", got.free_count, want.free_count);
          check_field("capacity_now", got.capacity_now, want.capacity_now);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_responses.push_back(predict_response(op_t'(in_tuser),
                                                     in_tdata[ID_W-1:0],
                                                     in_tdata[ID_W +: DATA_W],
                                                     in_tdata[ID_W+DATA_W +: BCNT_W]));
      end
      if (cfg_we) write_register(cfg_idx_t'(cfg_index), cfg_wdata);
    end
    pending_count <= pending_responses.size();
  end

endmodule

FILE: dv/tb_slot_pool_free_stack_top.sv
// ----------------------------------------------------------------------------
// tb_slot_pool_free_stack_top
// Drives the slot pool with a directed opening (fresh and recycled ids,
// partial stores, size and full checks, bad ids, free overflow, double free,
// growth, odd slot sizes) and then phases of random requests under changing
// register settings, with random gaps on the request side and random stalls
// on the result side. Prediction and comparison live in slot_pool_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slot_pool_free_stack_top;
  import spfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_count;
  int pending_count;

  // Requests in flight, so results can be tied back to stores
  typedef struct {
    op_t              op;
    logic [BCNT_W-1:0] cnt;
  } sent_req_t;

  sent_req_t   sent_reqs[$];
  int          held_ids[$];
  logic [7:0]  bytes_written [SLOTS] = '{default: '0};
  int unsigned slot_bytes_now = 8;
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;

  slot_pool_free_stack_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  slot_pool_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall per result, track which slot bytes hold data
  initial begin : receiver
    int unsigned        gap;
    sent_req_t          req;
    logic [ID_W-1:0]    gid;
    logic [8:0]         wmask;
    out_tready = 1'b0;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
      if (sent_reqs.size() != 0) begin
        req = sent_reqs.pop_front();
        gid = out_tdata[STAT_W +: ID_W];
        if (req.op == OP_STORE && status_t'(out_tdata[STAT_W-1:0]) == STAT_OK) begin
          wmask = (9'd1 << req.cnt) - 9'd1;
          bytes_written[gid] |= wmask[7:0];
          held_ids.push_back(gid);
        end
      end
    end
  end

  function automatic int unsigned eff_bytes();
    return (slot_bytes_now > SLOT_BYTES_MAX) ? SLOT_BYTES_MAX : slot_bytes_now;
  endfunction

  // A read is only issued when every byte it returns has been written
  function automatic bit slot_readable(input int unsigned id);
    logic [8:0] need;
    need = (9'd1 << eff_bytes()) - 9'd1;
    return (bytes_written[id] & need[7:0]) == need[7:0];
  endfunction

  task automatic send_req(input op_t op, input logic [ID_W-1:0] sid,
                          input logic [DATA_W-1:0] data, input logic [BCNT_W-1:0] cnt);
    int unsigned gap;
    sent_req_t   req;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({cnt, data, sid});
    do @(posedge clk); while (!(in_tvalid && in_tready));
    req.op  = op;
    req.cnt = cnt;
    sent_reqs.push_back(req);
  endtask

  // Stop requesting and wait until every result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // which is indexed by register: growable, initial_slots, grow_step, slot_bytes
  task automatic reconfigure(input logic [3:0] which, input logic g,
                             input logic [8:0] init, input logic [8:0] step,
                             input logic [3:0] sb);
    drain();
    repeat (2) @(posedge clk);
    if (which[CFG_GROWABLE]) cfg_put(CFG_GROWABLE, 9'(g));
    if (which[CFG_INIT_SLOTS]) begin
      cfg_put(CFG_INIT_SLOTS, init);
      held_ids.delete();
    end
    if (which[CFG_GROW_STEP]) cfg_put(CFG_GROW_STEP, step);
    if (which[CFG_SLOT_BYTES]) begin
      cfg_put(CFG_SLOT_BYTES, 9'(sb));
      slot_bytes_now = sb;
    end
    cfg_we <= 1'b0;
  endtask

  // One random request; mostly frees of ids handed out and reads of written slots
  task automatic random_request(input int unsigned store_pct, input int unsigned free_pct,
                                input int unsigned read_pct);
    int unsigned       roll;
    int unsigned       k;
    int unsigned       pick;
    int unsigned       id;
    bit                found;
    op_t               op;
    logic [ID_W-1:0]   sid;
    logic [DATA_W-1:0] data;
    logic [BCNT_W-1:0] cnt;
    roll = $urandom_range(0, 99);
    data = {$urandom, $urandom};
    sid  = $urandom_range(0, 255);
    cnt  = $urandom_range(0, 15);
    if (roll < store_pct) op = OP_STORE;
    else if (roll < store_pct + free_pct) op = OP_FREE;
    else if (roll < store_pct + free_pct + read_pct) op = OP_READ;
    else op = OP_BAD;
    if (op == OP_FREE) begin
      // mostly a live id, some double frees, some arbitrary ids
      k = $urandom_range(0, 99);
      if (held_ids.size() != 0 && k < 90) begin
        pick = $urandom_range(0, held_ids.size() - 1);
        sid  = held_ids[pick];
        if (k < 80) held_ids.delete(pick);
      end
    end
    if (op == OP_READ) begin
      found = 1'b0;
      for (int t = 0; t < 32 && !found; t++) begin
        id = $urandom_range(0, 255);
        if (slot_readable(id)) begin
          sid   = id;
          found = 1'b1;
        end
      end
      if (!found) op = OP_STORE;
    end
    if (op == OP_STORE) begin
      k = $urandom_range(0, 99);
      if (k < 40) cnt = eff_bytes();
      else if (k < 85) cnt = $urandom_range(0, eff_bytes());
    end
    send_req(op, sid, data, cnt);
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned store_pct,
                           input int unsigned free_pct, input int unsigned read_pct);
    for (int i = 0; i < n_items; i++) begin
      // occasional stretches with no idling on either side
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_request(store_pct, free_pct, read_pct);
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    logic       g;
    logic [8:0] init;
    logic [8:0] step;
    logic [3:0] sb;
    logic [3:0] which;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_STORE;
    cfg_we    = 1'b0;
    cfg_index = CFG_GROWABLE;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: 256 slots, fixed, 8-byte slots. Fresh ids ascend.
    send_req(OP_STORE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_req(OP_STORE, 8'hFF, 64'h0000_0000_0000_0000, 4'd8);
    send_req(OP_STORE, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd8);
    send_req(OP_STORE, 8'h00, 64'hA5A5_A5A5_A5A5_A5A5, 4'd3);
    // size check, including the widest byte count
    send_req(OP_STORE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
    send_req(OP_STORE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_req(OP_READ, 8'd0, 64'h0, 4'd0);
    // recycled id comes back first; partial store keeps the upper bytes
    send_req(OP_FREE, 8'd0, 64'h0, 4'd0);
    send_req(OP_STORE, 8'h00, 64'h1122_3344_5566_BEEF, 4'd2);
    send_req(OP_READ, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
    // double free is accepted and the id is served twice
    send_req(OP_FREE, 8'd0, 64'h0, 4'd0);
    send_req(OP_FREE, 8'd0, 64'h0, 4'd0);
    send_req(OP_STORE, 8'h00, 64'h8000_0000_0000_0001, 4'd8);
    send_req(OP_STORE, 8'h00, 64'h7FFF_FFFF_FFFF_FFFE, 4'd8);
    send_req(OP_BAD, 8'hAA, 64'h5555_5555_5555_5555, 4'd5);

    // Two-slot pool: full, size before full, bad id, free overflow
    reconfigure(4'b0010, 1'b0, 9'd2, 9'd0, 4'd8);
    send_req(OP_STORE, 8'h00, 64'hDEAD_BEEF_CAFE_F00D, 4'd8);
    send_req(OP_STORE, 8'h00, 64'h0F0F_0F0F_0F0F_0F0F, 4'd8);
    send_req(OP_STORE, 8'h00, 64'h1, 4'd1);
    send_req(OP_STORE, 8'h00, 64'h1, 4'd9);
    send_req(OP_READ, 8'd2, 64'h0, 4'd0);
    send_req(OP_FREE, 8'd200, 64'h0, 4'd0);
    send_req(OP_FREE, 8'd1, 64'h0, 4'd0);
    send_req(OP_FREE, 8'd0, 64'h0, 4'd0);
    send_req(OP_FREE, 8'd1, 64'h0, 4'd0);

    // Empty growable pool: zero step cannot grow, then growth by three
    reconfigure(4'b1111, 1'b1, 9'd0, 9'd0, 4'd8);
    send_req(OP_STORE, 8'h00, 64'h1, 4'd1);
    // zero-byte slots: only empty stores, reads return zero
    reconfigure(4'b1100, 1'b1, 9'd0, 9'd3, 4'd0);
    send_req(OP_STORE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_req(OP_STORE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
    send_req(OP_READ, 8'd0, 64'h0, 4'd0);
    // slot size above the maximum counts as the maximum
    reconfigure(4'b1000, 1'b1, 9'd0, 9'd3, 4'd12);
    send_req(OP_READ, 8'd0, 64'h0, 4'd0);

    // Random phases under changing settings
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          // fill past the pool limit with partial growth
          reconfigure(4'b1111, 1'b1, 9'd180, 9'd7, 4'd8);
          run_phase(320, 90, 6, 3);
        end
        1: begin
          // no reinit: the pool keeps its contents
          reconfigure(4'b1101, 1'b0, 9'd0, 9'd511, 4'd15);
          run_phase(125, 45, 35, 17);
        end
        2: begin
          reconfigure(4'b1111, 1'b0, 9'd511, 9'd0, 4'd1);
          run_phase(125, 45, 35, 17);
        end
        3: begin
          reconfigure(4'b1111, 1'b1, 9'd1, 9'd1, 4'd4);
          run_phase(125, 45, 35, 17);
        end
        4: begin
          reconfigure(4'b1111, 1'b1, 9'd0, 9'd256, 4'd8);
          run_phase(125, 45, 35, 17);
        end
        5: begin
          reconfigure(4'b1111, 1'b0, 9'd16, 9'd511, 4'd0);
          run_phase(125, 45, 35, 17);
        end
        default: begin
          g     = $urandom_range(0, 1);
          init  = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 24);
          step  = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 8);
          sb    = $urandom_range(0, 15);
          which = (p % 3 == 0) ? 4'b1001 : 4'b1111;
          reconfigure(which, g, init, step, sb);
          run_phase(125, 45, 35, 17);
        end
      endcase
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/spfs_pkg.sv
rtl/core/spfs_ram.sv
rtl/core/slot_pool_free_stack_top.sv
dv/slot_pool_checker.sv
dv/tb_slot_pool_free_stack_top.sv
